[hw/rtl/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants, codes and types for the byte ring buffer with peek/free.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH  = 1024;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int DATA_W = 8;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] DEPTH_C     = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_RESET   = CNT_W'(1024);

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_GET   = 2'd1,
        K_PEEK  = 2'd2,
        K_FREE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERFREE = 2'd3
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  data_in;
        logic [CNT_W-1:0]   count;
    } t_item;

    typedef struct packed {
        logic [PTR_W-1:0] rp;
        logic [PTR_W-1:0] wp;
        logic             empty;
    } t_ptr_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [PTR_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } t_ram_req;

    typedef struct packed {
        logic             byte_valid;
        logic [CNT_W-1:0] next_offset;
        logic [CNT_W-1:0] used_bytes;
        logic [CNT_W-1:0] free_span;
        logic [CNT_W-1:0] read_span;
        t_status          status;
    } t_res;

endpackage

[hw/rtl/brb_in_if.sv]
// ----------------------------------------------------------------------------
// brb_in_if
// Operation channel: kind, data byte and offset/count.
// ----------------------------------------------------------------------------
interface brb_in_if import brb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [DATA_W-1:0] data_in;
    logic [CNT_W-1:0]  count;

    modport source (output valid, kind, data_in, count, input ready);
    modport sink   (input valid, kind, data_in, count, output ready);
endinterface

[hw/rtl/brb_out_if.sv]
// ----------------------------------------------------------------------------
// brb_out_if
// Result channel: returned byte, offsets, fill figures and status.
// ----------------------------------------------------------------------------
interface brb_out_if import brb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              byte_valid;
    logic [CNT_W-1:0]  next_offset;
    logic [CNT_W-1:0]  used_bytes;
    logic [CNT_W-1:0]  free_span;
    logic [CNT_W-1:0]  read_span;
    logic [1:0]        status;

    modport source (output valid, data_out, byte_valid, next_offset, used_bytes,
                    free_span, read_span, status, input ready);
    modport sink   (input valid, data_out, byte_valid, next_offset, used_bytes,
                    free_span, read_span, status, output ready);
endinterface

[hw/rtl/brb_cfg_if.sv]
// ----------------------------------------------------------------------------
// brb_cfg_if
// Configuration write channel carrying the capacity register.
// ----------------------------------------------------------------------------
interface brb_cfg_if import brb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

[hw/rtl/brb_ram.sv]
// ----------------------------------------------------------------------------
// brb_ram
// Single-port synchronous RAM, registered read data held between reads.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/brb_calc.sv]
// ----------------------------------------------------------------------------
// brb_calc
// Pointer arithmetic for one operation: next pointers, RAM access, result.
// ----------------------------------------------------------------------------
module brb_calc import brb_pkg::*; (
    input  t_ptr_state       i_state,
    input  t_item            i_item,
    input  logic [CNT_W-1:0] i_capacity,
    output t_ptr_state       o_state,
    output t_ram_req         o_ram,
    output t_res             o_res
);

    localparam logic [CNT_W-PTR_W-1:0] PAD = '0;

    function automatic logic [CNT_W-1:0] used_of(
        input logic             empty,
        input logic [CNT_W-1:0] rpx,
        input logic [CNT_W-1:0] wpx,
        input logic [CNT_W-1:0] cap
    );
        logic [CNT_W-1:0] u;
        if (empty) begin
            u = '0;
        end else if (rpx < wpx) begin
            u = wpx - rpx;
        end else begin
            u = (cap - rpx) + wpx;
        end
        return u;
    endfunction

    logic [CNT_W-1:0] cap;
    t_ptr_state       cur;
    t_ptr_state       nxt;
    logic [CNT_W-1:0] rpx;
    logic [CNT_W-1:0] wpx;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] step;
    logic [CNT_W:0]   sum;
    logic [CNT_W:0]   wrap;
    logic [CNT_W-1:0] winc;
    logic [CNT_W-1:0] wnext;
    logic             full;
    logic             peek_ok;
    logic [CNT_W-1:0] n_rpx;
    logic [CNT_W-1:0] n_wpx;
    logic [CNT_W-1:0] used_after;

    always_comb begin
        if (i_capacity == '0) begin
            cap = CNT_W'(1);
        end else if (i_capacity > DEPTH_C) begin
            cap = DEPTH_C;
        end else begin
            cap = i_capacity;
        end

        // pointers beyond the active range drop the contents
        if ({PAD, i_state.rp} >= cap || {PAD, i_state.wp} >= cap) begin
            cur = '{rp: '0, wp: '0, empty: 1'b1};
        end else begin
            cur = i_state;
        end
        rpx  = {PAD, cur.rp};
        wpx  = {PAD, cur.wp};
        used = used_of(cur.empty, rpx, wpx, cap);
        full = !cur.empty && (cur.rp == cur.wp);

        // shared read-side adder: +1 for get, +count for peek and free
        step = (i_item.kind == K_GET) ? CNT_W'(1) : i_item.count;
        sum  = {1'b0, rpx} + {1'b0, step};
        wrap = (sum >= {1'b0, cap}) ? (sum - {1'b0, cap}) : sum;

        winc  = wpx + CNT_W'(1);
        wnext = (winc >= cap) ? '0 : winc;

        nxt     = cur;
        peek_ok = 1'b0;
        o_ram   = '{we: 1'b0, re: 1'b0, addr: cur.wp, wdata: i_item.data_in};
        o_res.byte_valid = 1'b0;
        o_res.status     = ST_OK;

        unique case (i_item.kind)
            K_WRITE: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_ram.we  = 1'b1;
                    nxt.empty = 1'b0;
                    nxt.wp    = wnext[PTR_W-1:0];
                end
            end
            K_GET: begin
                if (cur.empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_ram.re         = 1'b1;
                    o_ram.addr       = cur.rp;
                    o_res.byte_valid = 1'b1;
                    if (wrap[PTR_W-1:0] == cur.wp) begin
                        nxt = '{rp: '0, wp: '0, empty: 1'b1};
                    end else begin
                        nxt.rp = wrap[PTR_W-1:0];
                    end
                end
            end
            K_PEEK: begin
                if (i_item.count >= used) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_ram.re         = 1'b1;
                    o_ram.addr       = wrap[PTR_W-1:0];
                    o_res.byte_valid = 1'b1;
                    peek_ok          = 1'b1;
                end
            end
            K_FREE: begin
                if (i_item.count > used) begin
                    o_res.status = ST_OVERFREE;
                end else if (i_item.count == used || wrap[PTR_W-1:0] == cur.wp) begin
                    nxt = '{rp: '0, wp: '0, empty: 1'b1};
                end else begin
                    nxt.rp = wrap[PTR_W-1:0];
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase

        n_rpx      = {PAD, nxt.rp};
        n_wpx      = {PAD, nxt.wp};
        used_after = used_of(nxt.empty, n_rpx, n_wpx, cap);

        o_res.used_bytes  = used_after;
        o_res.next_offset = peek_ok ? (i_item.count + CNT_W'(1)) : used_after;

        if (nxt.empty || n_rpx < n_wpx) begin
            o_res.free_span = cap - n_wpx;
        end else begin
            o_res.free_span = n_rpx - n_wpx;
        end

        if (nxt.empty) begin
            o_res.read_span = '0;
        end else if (n_rpx >= n_wpx) begin
            o_res.read_span = cap - n_rpx;
        end else begin
            o_res.read_span = n_wpx - n_rpx;
        end

        o_state = nxt;
    end

endmodule

[hw/rtl/byte_ring_buffer_peek_free_core.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_free_core
// Byte ring buffer with write, get, peek-at-offset and bulk free operations.
//
//   channel   dir   payload                                           role
//   i_in      in    kind, data_in, count                              operation
//   o_out     out   data_out, byte_valid, next_offset, used_bytes,    result
//                   free_span, read_span, status
//   i_cfg     in    capacity                                          register
//
// For an operation, pointers update and the byte RAM is read or written at
// the accept edge; the registered read data moves into the output register
// from the load state once o_out can take it.
// i_in is ready again once the result has moved into the output register,
// so a new transfer is taken while the previous result waits on o_out.
// While o_out is stalled with a result waiting, the next item holds in the
// load state and i_in stays low.
// Reset empties the buffer and sets capacity to 1024; RAM contents stay.
// A capacity write empties the buffer.
// ----------------------------------------------------------------------------
module byte_ring_buffer_peek_free_core import brb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brb_in_if.sink     i_in,
    brb_out_if.source  o_out,
    brb_cfg_if.sink    i_cfg
);

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    t_state            r_state;
    t_ptr_state        r_ptr;
    logic [CNT_W-1:0]  r_cap;
    t_res              r_res;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_data_out;
    t_res              r_ores;

    t_item             item;
    t_ptr_state        n_ptr;
    t_ram_req          ram_req;
    t_res              res;
    logic [DATA_W-1:0] rdata;
    logic              in_xfer;
    logic              cfg_xfer;
    logic              out_free;

    assign item = '{kind: t_kind'(i_in.kind), data_in: i_in.data_in, count: i_in.count};

    assign in_xfer  = i_in.valid && i_in.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_ovalid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    brb_calc u_calc (
        .i_state    (r_ptr),
        .i_item     (item),
        .i_capacity (r_cap),
        .o_state    (n_ptr),
        .o_ram      (ram_req),
        .o_res      (res)
    );

    brb_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we && in_xfer),
        .i_re    (ram_req.re && in_xfer),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '{rp: '0, wp: '0, empty: 1'b1};
            r_cap    <= CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_ovalid && o_out.ready) begin
                        r_ovalid <= 1'b0;
                    end
                    if (in_xfer) begin
                        r_res   <= res;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // out_free low means a result waits and o_out is stalled
                    if (out_free) begin
                        r_data_out <= r_res.byte_valid ? rdata : '0;
                        r_ores     <= r_res;
                        r_ovalid   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (cfg_xfer) begin
                r_cap <= i_cfg.capacity;
                r_ptr <= '{rp: '0, wp: '0, empty: 1'b1};
            end else if (in_xfer) begin
                r_ptr <= n_ptr;
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.data_out    = r_data_out;
    assign o_out.byte_valid  = r_ores.byte_valid;
    assign o_out.next_offset = r_ores.next_offset;
    assign o_out.used_bytes  = r_ores.used_bytes;
    assign o_out.free_span   = r_ores.free_span;
    assign o_out.read_span   = r_ores.read_span;
    assign o_out.status      = r_ores.status;

endmodule
